>>> rtl/bar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_pkg
// Shared widths, codes, types and span helpers for the area resampler.
// ----------------------------------------------------------------------------
package bar_pkg;

	localparam int DIM_W       = 13;
	localparam int COORD_W     = 12;
	localparam int LO_W        = DIM_W + 1;
	localparam int UP_W        = DIM_W + 4;
	localparam int CHAN_W      = 8;
	localparam int SUM_W       = 32;
	localparam int AREA_W      = 25;
	localparam int DIV_CNT_W   = $clog2(SUM_W);
	localparam int DEPTH       = 4096;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int MAX_SRC_DIM = 4096;
	localparam int MAX_DST_DIM = 4096;
	localparam int MAX_UPSCALE = 8;
	localparam int LIST_N      = MAX_UPSCALE + 1;
	localparam int LIST_W      = $clog2(LIST_N + 1);
	localparam int MAX_RES     = 64;
	localparam int RES_W       = $clog2(MAX_RES + 1);
	localparam int NUM_LANES   = 4;
	localparam int IDX_W       = 3;

	localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
	localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

	localparam logic [DIM_W-1:0] DIM_RESET = 13'd256;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_ROWS,
		ST_COLS,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic              load;
		logic              div_start;
		logic              wb;
		logic              wb_clear;
		logic [ADDR_W-1:0] addr;
	} lane_ctrl_t;

	// lo = floor(i*s/d), rem = i*s mod d
	typedef struct packed {
		logic [LO_W-1:0]  lo;
		logic [DIM_W-1:0] rem;
	} span_t;

	// advance i -> i+1, with q = s/d and r = s%d
	function automatic span_t span_step(span_t cur, logic [DIM_W-1:0] q,
			logic [DIM_W-1:0] r, logic [DIM_W-1:0] d);
		logic [DIM_W:0] acc;
		span_t nxt;
		acc = {1'b0, cur.rem} + {1'b0, r};
		if (acc >= {1'b0, d}) begin
			nxt.rem = DIM_W'(acc - {1'b0, d});
			nxt.lo  = cur.lo + LO_W'(q) + LO_W'(1);
		end else begin
			nxt.rem = acc[DIM_W-1:0];
			nxt.lo  = cur.lo + LO_W'(q);
		end
		return nxt;
	endfunction

	// exclusive end of a range: at least one wide, capped at the source size
	function automatic logic [LO_W-1:0] span_top(logic [LO_W-1:0] lo,
			logic [LO_W-1:0] nlo, logic [DIM_W-1:0] s);
		logic [LO_W-1:0] hi;
		hi = (nlo > lo) ? nlo : lo + LO_W'(1);
		if (hi > LO_W'(s))
			hi = LO_W'(s);
		return hi;
	endfunction

endpackage

>>> rtl/bar_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_pixel_if
// Source pixel channel: valid/ready with one RGBA8 pixel.
// ----------------------------------------------------------------------------
interface bar_pixel_if import bar_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red_in;
	logic [CHAN_W-1:0] green_in;
	logic [CHAN_W-1:0] blue_in;
	logic [CHAN_W-1:0] alpha_in;

	modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

>>> rtl/bar_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_result_if
// Destination pixel channel: valid/ready with coordinates, averages and flags.
// ----------------------------------------------------------------------------
interface bar_result_if import bar_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] dest_x;
	logic [COORD_W-1:0] dest_y;
	logic [CHAN_W-1:0]  red_out;
	logic [CHAN_W-1:0]  green_out;
	logic [CHAN_W-1:0]  blue_out;
	logic [CHAN_W-1:0]  alpha_out;
	logic               run_last;
	logic               frame_done;
	logic               config_error;

	modport source (output valid, dest_x, dest_y, red_out, green_out, blue_out, alpha_out,
		run_last, frame_done, config_error, input ready);
	modport sink (input valid, dest_x, dest_y, red_out, green_out, blue_out, alpha_out,
		run_last, frame_done, config_error, output ready);
endinterface

>>> rtl/bar_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bar_div import bar_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [AREA_W-1:0] divisor,
	output logic [SUM_W-1:0]  quotient,
	output logic [AREA_W-1:0] remainder,
	output logic              done
);

	logic [SUM_W-1:0]     quo_q;
	logic [AREA_W-1:0]    rem_q;
	logic [AREA_W-1:0]    div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [AREA_W:0]      trial;
	logic                 ge;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? AREA_W'(trial - {1'b0, div_q}) : trial[AREA_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

>>> rtl/bar_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_lane
// One color channel: per-column sum memory, accumulate, and average divider.
// ----------------------------------------------------------------------------
module bar_lane import bar_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  lane_ctrl_t        ctrl,
	input  logic [CHAN_W-1:0] chan,
	input  logic [AREA_W-1:0] area,
	output logic [CHAN_W-1:0] avg,
	output logic              done
);

	logic [SUM_W-1:0]  mem [DEPTH];
	logic [SUM_W-1:0]  rd_s1;
	logic [CHAN_W-1:0] chan_s1;
	logic              rd_v_s1;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  quo;

	always_ff @(posedge clk) begin
		if (ctrl.wb)
			mem[ctrl.addr] <= ctrl.wb_clear ? '0 : sum_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rd_s1   <= mem[ctrl.addr];
			chan_s1 <= chan;
		end
		if (rd_v_s1)
			sum_q <= rd_s1 + SUM_W'(chan_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_v_s1 <= 1'b0;
		else
			rd_v_s1 <= ctrl.load;
	end

	bar_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctrl.div_start),
		.dividend  (sum_q),
		.divisor   (area),
		.quotient  (quo),
		.remainder (),
		.done      (done)
	);

	assign avg = quo[CHAN_W-1:0];

endmodule

>>> rtl/box_area_image_resampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_area_image_resampler_unit
// Area-average RGBA8 resampler: four channel lanes, span walker, result merge.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  pixel    | in  | pixel.valid/ready    | red_in, green_in, blue_in, alpha_in
//  result   | out | result.valid/ready   | dest_x/y, 4 averages, run_last,
//           |     |                      | frame_done, config_error
//  config   | in  | wr_en (no stall)     | wr_index, wr_data
//
//  One pixel at a time. A pixel walks the destination columns it touches;
//  the first pixel of a source row first walks the destination rows too.
//  Each result takes the area multiply, the divider start, the wait until
//  the bit-serial divide of the 32-bit sums is done in all four lanes,
//  then the request. After reset and after every register write a pass
//  clears all 4096 column sums; ready stays low during it. Output stalls
//  hold the block.
// ----------------------------------------------------------------------------
module box_area_image_resampler_unit import bar_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_index,
	input  logic [DIM_W-1:0]   wr_data,
	bar_pixel_if.sink          pixel,
	bar_result_if.source       result
);

	state_t state_q, state_d;

	logic [DIM_W-1:0]  sw_q, sh_q, dw_q, dh_q;
	logic              cdiv_start_q;
	logic [ADDR_W-1:0] clr_q;
	logic [SUM_W-1:0]  qx_full, qy_full;
	logic [AREA_W-1:0] rx_full, ry_full;
	logic              cx_done, cy_done;
	logic [DIM_W-1:0]  q_x, r_x, q_y, r_y;
	logic              cfg_bad, bad, cfg_hit, in_acc, out_acc;

	logic [COORD_W-1:0] sx_q, sy_q;
	logic [DIM_W-1:0]   g_q, br_q, ng_q, nb_q, w_q;
	span_t              g_sp_q, br_sp_q, ng_sp_q, nb_sp_q, w_sp_q, w_nxt;
	logic               found_q;

	logic [DIM_W-1:0] wd, ws, wq, wr;
	logic [LO_W-1:0]  wpos, hi;
	logic             w_in, w_close, w_past;
	logic [DIM_W-1:0] span_len;

	logic [COORD_W-1:0] row_y_q [LIST_N];
	logic [DIM_W-1:0]   row_h_q [LIST_N];
	logic [COORD_W-1:0] col_x_q [LIST_N];
	logic [DIM_W-1:0]   col_w_q [LIST_N];
	logic [LIST_W-1:0]  nr_q, nc_q, i_q, j_q;
	logic [RES_W-1:0]   k_q;
	logic [2*DIM_W-1:0] prod;
	logic [AREA_W-1:0]  area_q;

	logic [COORD_W-1:0] ox_q, oy_q;
	logic [CHAN_W-1:0]  ored_q, ogreen_q, oblue_q, oalpha_q;
	logic               olast_q, odone_q, oerr_q;

	lane_ctrl_t         lctl;
	logic [CHAN_W-1:0]  lane_in  [NUM_LANES];
	logic [CHAN_W-1:0]  lane_avg [NUM_LANES];
	logic [NUM_LANES-1:0] lane_done;

	// configuration
	always_comb begin
		cfg_hit = 1'b0;
		unique case (wr_index)
			REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT: cfg_hit = wr_en;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= DIM_RESET;
			sh_q <= DIM_RESET;
			dw_q <= DIM_RESET;
			dh_q <= DIM_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SRC_WIDTH:  sw_q <= wr_data;
				REG_SRC_HEIGHT: sh_q <= wr_data;
				REG_DST_WIDTH:  dw_q <= wr_data;
				REG_DST_HEIGHT: dh_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg_bad = (sw_q == '0) || (sh_q == '0) || (dw_q == '0) || (dh_q == '0)
			|| (sw_q > DIM_W'(MAX_SRC_DIM)) || (sh_q > DIM_W'(MAX_SRC_DIM))
			|| (dw_q > DIM_W'(MAX_DST_DIM)) || (dh_q > DIM_W'(MAX_DST_DIM))
			|| (UP_W'(dw_q) > UP_W'(sw_q) * UP_W'(MAX_UPSCALE))
			|| (UP_W'(dh_q) > UP_W'(sh_q) * UP_W'(MAX_UPSCALE));
		bad = cfg_bad || (g_q >= dw_q);
	end

	// step quotient/remainder per axis, recomputed after each write
	bar_div u_cdiv_x (
		.clk(clk), .arst_n(arst_n), .start(cdiv_start_q),
		.dividend(SUM_W'(sw_q)), .divisor(AREA_W'(dw_q)),
		.quotient(qx_full), .remainder(rx_full), .done(cx_done)
	);

	bar_div u_cdiv_y (
		.clk(clk), .arst_n(arst_n), .start(cdiv_start_q),
		.dividend(SUM_W'(sh_q)), .divisor(AREA_W'(dh_q)),
		.quotient(qy_full), .remainder(ry_full), .done(cy_done)
	);

	assign q_x = qx_full[DIM_W-1:0];
	assign r_x = rx_full[DIM_W-1:0];
	assign q_y = qy_full[DIM_W-1:0];
	assign r_y = ry_full[DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cdiv_start_q <= 1'b1;
			clr_q        <= '0;
		end else begin
			cdiv_start_q <= cfg_hit;
			if (cfg_hit)
				clr_q <= '0;
			else if (state_q == ST_INIT)
				clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// range walker, shared by the row and column passes
	always_comb begin
		if (state_q == ST_ROWS) begin
			wd = dh_q; ws = sh_q; wq = q_y; wr = r_y; wpos = LO_W'(sy_q);
		end else begin
			wd = dw_q; ws = sw_q; wq = q_x; wr = r_x; wpos = LO_W'(sx_q);
		end
		w_nxt    = span_step(w_sp_q, wq, wr, wd);
		hi       = span_top(w_sp_q.lo, w_nxt.lo, ws);
		w_in     = (w_q < wd) && (w_sp_q.lo <= wpos);
		w_close  = hi == wpos + LO_W'(1);
		w_past   = hi > wpos + LO_W'(1);
		span_len = DIM_W'(hi - w_sp_q.lo);
	end

	assign in_acc  = pixel.valid && pixel.ready;
	assign out_acc = result.valid && result.ready;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_INIT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d        = state_q;
		lctl.load      = 1'b0;
		lctl.div_start = 1'b0;
		lctl.wb        = 1'b0;
		lctl.wb_clear  = 1'b0;
		lctl.addr      = g_q[ADDR_W-1:0];
		pixel.ready    = 1'b0;
		result.valid   = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				lctl.wb       = 1'b1;
				lctl.wb_clear = 1'b1;
				lctl.addr     = clr_q;
				if (clr_q == ADDR_W'(DEPTH - 1) && cx_done && cy_done && !cdiv_start_q)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				pixel.ready = 1'b1;
				lctl.load   = in_acc && !bad;
				if (in_acc) begin
					if (bad)
						state_d = ST_OUT;
					else if (sx_q == '0)
						state_d = ST_ROWS;
					else
						state_d = ST_COLS;
				end
			end
			ST_ROWS: begin
				if (!w_in)
					state_d = ST_COLS;
			end
			ST_COLS: begin
				if (!w_in)
					state_d = (nr_q != '0 && nc_q != '0) ? ST_MUL : ST_FIN;
			end
			ST_MUL:    state_d = ST_DIV_GO;
			ST_DIV_GO: begin
				lctl.div_start = 1'b1;
				state_d        = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (&lane_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				result.valid = 1'b1;
				if (out_acc)
					state_d = oerr_q ? ST_IDLE : (olast_q ? ST_FIN : ST_MUL);
			end
			ST_FIN: begin
				lctl.wb       = 1'b1;
				lctl.wb_clear = (nr_q != '0) && (nc_q != '0);
				state_d       = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
		if (cfg_hit)
			state_d = ST_INIT;
	end

	// position, trackers, walk and emit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0; sy_q <= '0;
			g_q <= '0; g_sp_q <= '0; br_q <= '0; br_sp_q <= '0;
			ng_q <= '0; ng_sp_q <= '0; nb_q <= '0; nb_sp_q <= '0;
			w_q <= '0; w_sp_q <= '0; found_q <= 1'b0;
			nr_q <= '0; nc_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0;
		end else if (cfg_hit) begin
			sx_q <= '0; sy_q <= '0;
			g_q <= '0; g_sp_q <= '0; br_q <= '0; br_sp_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && !bad) begin
						found_q <= 1'b0;
						nc_q    <= '0;
						if (sx_q == '0) begin
							w_q    <= br_q;
							w_sp_q <= br_sp_q;
							nr_q   <= '0;
						end else begin
							w_q    <= g_q;
							w_sp_q <= g_sp_q;
						end
					end
				end
				ST_ROWS: begin
					if (w_in) begin
						if (w_close && nr_q < LIST_W'(LIST_N))
							nr_q <= nr_q + LIST_W'(1);
						if (w_past && !found_q) begin
							nb_q    <= w_q;
							nb_sp_q <= w_sp_q;
							found_q <= 1'b1;
						end
						w_q    <= w_q + DIM_W'(1);
						w_sp_q <= w_nxt;
					end else begin
						if (!found_q) begin
							nb_q    <= w_q;
							nb_sp_q <= w_sp_q;
						end
						found_q <= 1'b0;
						w_q     <= g_q;
						w_sp_q  <= g_sp_q;
					end
				end
				ST_COLS: begin
					if (w_in) begin
						if (w_close && nc_q < LIST_W'(LIST_N))
							nc_q <= nc_q + LIST_W'(1);
						if (w_past && !found_q) begin
							ng_q    <= w_q;
							ng_sp_q <= w_sp_q;
							found_q <= 1'b1;
						end
						w_q    <= w_q + DIM_W'(1);
						w_sp_q <= w_nxt;
					end else begin
						if (!found_q) begin
							ng_q    <= w_q;
							ng_sp_q <= w_sp_q;
						end
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
					end
				end
				ST_OUT: begin
					if (out_acc && !oerr_q) begin
						k_q <= k_q + RES_W'(1);
						if (j_q == nc_q - LIST_W'(1)) begin
							j_q <= '0;
							i_q <= i_q + LIST_W'(1);
						end else begin
							j_q <= j_q + LIST_W'(1);
						end
					end
				end
				ST_FIN: begin
					if (DIM_W'(sx_q) + DIM_W'(1) >= sw_q) begin
						sx_q   <= '0;
						g_q    <= '0;
						g_sp_q <= '0;
						if (DIM_W'(sy_q) + DIM_W'(1) >= sh_q) begin
							sy_q    <= '0;
							br_q    <= '0;
							br_sp_q <= '0;
						end else begin
							sy_q    <= sy_q + COORD_W'(1);
							br_q    <= nb_q;
							br_sp_q <= nb_sp_q;
						end
					end else begin
						sx_q   <= sx_q + COORD_W'(1);
						g_q    <= ng_q;
						g_sp_q <= ng_sp_q;
					end
				end
				default: ;
			endcase
		end
	end

	// closing lists, area, and the merge into the output register
	assign prod = (2*DIM_W)'(row_h_q[i_q]) * (2*DIM_W)'(col_w_q[j_q]);

	always_ff @(posedge clk) begin
		if (state_q == ST_ROWS && w_in && w_close && nr_q < LIST_W'(LIST_N)) begin
			row_y_q[nr_q] <= COORD_W'(w_q);
			row_h_q[nr_q] <= span_len;
		end
		if (state_q == ST_COLS && w_in && w_close && nc_q < LIST_W'(LIST_N)) begin
			col_x_q[nc_q] <= COORD_W'(w_q);
			col_w_q[nc_q] <= span_len;
		end
		if (state_q == ST_MUL)
			area_q <= (prod == '0) ? AREA_W'(1) : prod[AREA_W-1:0];
		if (state_q == ST_DIV_WAIT && (&lane_done)) begin
			ox_q     <= col_x_q[j_q];
			oy_q     <= row_y_q[i_q];
			ored_q   <= lane_avg[0];
			ogreen_q <= lane_avg[1];
			oblue_q  <= lane_avg[2];
			oalpha_q <= lane_avg[3];
			olast_q  <= (k_q == RES_W'(MAX_RES - 1))
				|| (i_q == nr_q - LIST_W'(1) && j_q == nc_q - LIST_W'(1));
			odone_q  <= (DIM_W'(col_x_q[j_q]) == dw_q - DIM_W'(1))
				&& (DIM_W'(row_y_q[i_q]) == dh_q - DIM_W'(1));
			oerr_q   <= 1'b0;
		end else if (state_q == ST_IDLE && in_acc && bad) begin
			ox_q     <= '0;
			oy_q     <= '0;
			ored_q   <= '0;
			ogreen_q <= '0;
			oblue_q  <= '0;
			oalpha_q <= '0;
			olast_q  <= 1'b1;
			odone_q  <= 1'b0;
			oerr_q   <= 1'b1;
		end
	end

	// channel lanes
	assign lane_in[0] = pixel.red_in;
	assign lane_in[1] = pixel.green_in;
	assign lane_in[2] = pixel.blue_in;
	assign lane_in[3] = pixel.alpha_in;

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		bar_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lctl),
			.chan   (lane_in[l]),
			.area   (area_q),
			.avg    (lane_avg[l]),
			.done   (lane_done[l])
		);
	end

	assign result.dest_x       = ox_q;
	assign result.dest_y       = oy_q;
	assign result.red_out      = ored_q;
	assign result.green_out    = ogreen_q;
	assign result.blue_out     = oblue_q;
	assign result.alpha_out    = oalpha_q;
	assign result.run_last     = olast_q;
	assign result.frame_done   = odone_q;
	assign result.config_error = oerr_q;

	// checks
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready) |=> !pixel.ready)
		else $error("pixel taken while previous pixel in flight");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(pixel.ready && result.valid))
		else $error("input open while a result is pending");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.config_error) |-> result.run_last)
		else $error("error result without run_last");

	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(nr_q <= LIST_W'(LIST_N)) && (nc_q <= LIST_W'(LIST_N)))
		else $error("closing list overflow");

endmodule
